[rtl/core/hjbp_pkg.sv]
// ============================================================================
// hjbp_pkg
// Shared sizes, codes and types of the hash join build/probe engine.
// ============================================================================
package hjbp_pkg;

   // Table geometry. BUCKETS is a power of two: the bucket is the low key bits.
   localparam int ENTRIES     = 1024;
   localparam int BUCKETS     = 256;
   localparam int MAX_MATCHES = 64;

   localparam int EIDX_W = $clog2(ENTRIES);          // entry index
   localparam int BIDX_W = $clog2(BUCKETS);          // bucket index
   localparam int CNT_W  = $clog2(ENTRIES + 1);      // entry fill count
   localparam int MCNT_W = $clog2(MAX_MATCHES + 1);  // matches per probe

   // Payload widths
   localparam int CMD_W = 2;
   localparam int KEY_W = 64;
   localparam int ROW_W = 16;
   localparam int STS_W = 2;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_BUILD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PROBE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

   // Result status codes
   localparam logic [STS_W-1:0] ST_MATCH = 2'd0;
   localparam logic [STS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STS_W-1:0] ST_TRUNC = 2'd2;

   // One stored table entry
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic              text;
      logic [ROW_W-1:0]  row;
      logic              next_valid;
      logic [EIDX_W-1:0] next;
   } entry_type;

   // Bucket head memory access
   typedef struct packed {
      logic              we;
      logic [BIDX_W-1:0] waddr;
      logic [EIDX_W-1:0] wdata;
      logic              re;
      logic [BIDX_W-1:0] raddr;
   } head_port_type;

   // Entry memory access
   typedef struct packed {
      logic              we;
      logic [EIDX_W-1:0] waddr;
      entry_type         wdata;
      logic              re;
      logic [EIDX_W-1:0] raddr;
   } ent_port_type;

   // One result
   typedef struct packed {
      logic [ROW_W-1:0] left_row;
      logic [ROW_W-1:0] right_row;
      logic [STS_W-1:0] status;
      logic             last;
   } result_type;

endpackage

[rtl/core/hjbp_if.sv]
// ============================================================================
// hjbp_if
// Valid/ready channels of the join engine: request in, result out.
// ============================================================================
interface hjbp_req_if import hjbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [KEY_W-1:0] key;
   logic             key_is_text;
   logic [ROW_W-1:0] row_id;

   modport source (output valid, command, key, key_is_text, row_id, input ready);
   modport sink   (input valid, command, key, key_is_text, row_id, output ready);
endinterface

interface hjbp_rsp_if import hjbp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] left_row;
   logic [ROW_W-1:0] right_row;
   logic [STS_W-1:0] status;
   logic             last;

   modport source (output valid, left_row, right_row, status, last, input ready);
   modport sink   (input valid, left_row, right_row, status, last, output ready);
endinterface

[rtl/core/hjbp_ram.sv]
// ============================================================================
// hjbp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ============================================================================
module hjbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Read port, data held while no read is issued
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/hjbp_rsp_reg.sv]
// ============================================================================
// hjbp_rsp_reg
// Result output register: decouples the engine from the result channel.
// ============================================================================
module hjbp_rsp_reg import hjbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  result_type      res,
   output logic            can_push,
   hjbp_rsp_if.source      rsp
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Room when empty or being drained this cycle
   assign can_push = !valid_ff || rsp.ready;
   assign valid_in = push || (valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && can_push) begin
         data_ff <= res;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.left_row  = data_ff.left_row;
   assign rsp.right_row = data_ff.right_row;
   assign rsp.status    = data_ff.status;
   assign rsp.last      = data_ff.last;

endmodule

[rtl/core/hjbp_engine.sv]
// ============================================================================
// hjbp_engine
// Request sequencer: inserts into and walks the chained hash table held in
// the bucket head and entry memories, and issues results.
// ============================================================================
module hjbp_engine import hjbp_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   hjbp_req_if.sink          req,
   input  logic [EIDX_W-1:0] head_rdata,
   input  entry_type         ent_rdata,
   output head_port_type     head_port,
   output ent_port_type      ent_port,
   input  logic              can_push,
   output logic              push,
   output result_type        res
);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_INS   = 6'b000010,
      S_FULL  = 6'b000100,
      S_HEAD  = 6'b001000,
      S_WALK  = 6'b010000,
      S_FLUSH = 6'b100000
   } state_type;

   state_type          state_ff, state_in;
   logic [BUCKETS-1:0] hv_ff, hv_in;            // bucket chain present
   logic [CNT_W-1:0]   count_ff, count_in;      // entries in use
   logic               pend_valid_ff, pend_valid_in;
   logic [ROW_W-1:0]   pend_row_ff, pend_row_in;
   logic [MCNT_W-1:0]  nmatch_ff, nmatch_in;    // matches found, pending included
   logic [KEY_W-1:0]   key_ff, key_in;
   logic               text_ff, text_in;
   logic [ROW_W-1:0]   row_ff, row_in;

   logic               accept;
   logic [BIDX_W-1:0]  bucket_req;
   logic [BIDX_W-1:0]  bucket_ff;
   logic               matched;

   assign req.ready  = (state_ff == S_IDLE);
   assign accept     = req.valid && req.ready;
   assign bucket_req = req.key[BIDX_W-1:0];
   assign bucket_ff  = key_ff[BIDX_W-1:0];
   assign matched    = (ent_rdata.key == key_ff) && (ent_rdata.text == text_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      hv_in         = hv_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_row_in   = pend_row_ff;
      nmatch_in     = nmatch_ff;
      key_in        = key_ff;
      text_in       = text_ff;
      row_in        = row_ff;

      // head lookup goes out with every accepted request
      head_port       = '0;
      head_port.re    = accept;
      head_port.raddr = bucket_req;
      ent_port        = '0;

      push          = 1'b0;
      res.left_row  = pend_row_ff;
      res.right_row = row_ff;
      res.status    = ST_MATCH;
      res.last      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               key_in  = req.key;
               text_in = req.key_is_text;
               row_in  = req.row_id;
               case (req.command)
                  CMD_BUILD: begin
                     if (count_ff >= CNT_W'(ENTRIES)) begin
                        state_in = S_FULL;
                     end else begin
                        state_in = S_INS;
                     end
                  end
                  CMD_PROBE: begin
                     pend_valid_in = 1'b0;
                     nmatch_in     = '0;
                     if (hv_ff[bucket_req]) begin
                        state_in = S_HEAD;
                     end
                  end
                  CMD_CLEAR: begin
                     hv_in    = '0;
                     count_in = '0;
                  end
                  default: ;
               endcase
            end
         end

         // new entry at the chain head; old head becomes its successor
         S_INS: begin
            ent_port.we               = 1'b1;
            ent_port.waddr            = count_ff[EIDX_W-1:0];
            ent_port.wdata.key        = key_ff;
            ent_port.wdata.text       = text_ff;
            ent_port.wdata.row        = row_ff;
            ent_port.wdata.next_valid = hv_ff[bucket_ff];
            ent_port.wdata.next       = head_rdata;
            head_port.we              = 1'b1;
            head_port.waddr           = bucket_ff;
            head_port.wdata           = count_ff[EIDX_W-1:0];
            hv_in[bucket_ff]          = 1'b1;
            count_in                  = count_ff + CNT_W'(1);
            state_in                  = S_IDLE;
         end

         S_FULL: begin
            res.left_row = '0;
            res.status   = ST_FULL;
            res.last     = 1'b1;
            push         = can_push;
            if (can_push) begin
               state_in = S_IDLE;
            end
         end

         S_HEAD: begin
            ent_port.re    = 1'b1;
            ent_port.raddr = head_rdata;
            state_in       = S_WALK;
         end

         // one chain entry per cycle unless a match waits on a full result register;
         // a match is held back one step so the final one can be marked
         S_WALK: begin
            if (!(matched && pend_valid_ff && !can_push)) begin
               if (matched && (nmatch_ff == MCNT_W'(MAX_MATCHES))) begin
                  res.status = ST_TRUNC;
                  res.last   = 1'b1;
                  push       = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  if (matched) begin
                     push          = pend_valid_ff;
                     pend_valid_in = 1'b1;
                     pend_row_in   = ent_rdata.row;
                     nmatch_in     = nmatch_ff + MCNT_W'(1);
                  end
                  if (ent_rdata.next_valid) begin
                     ent_port.re    = 1'b1;
                     ent_port.raddr = ent_rdata.next;
                  end else begin
                     state_in = S_FLUSH;
                  end
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else begin
               res.last = 1'b1;
               push     = can_push;
               if (can_push) begin
                  state_in = S_IDLE;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         hv_ff         <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         nmatch_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         hv_ff         <= hv_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         nmatch_ff     <= nmatch_in;
      end
   end

   // Request payload and pending match
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      text_ff     <= text_in;
      row_ff      <= row_in;
      pend_row_ff <= pend_row_in;
   end

   // Checks
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("entry count beyond table size");

   a_nmatch_max: assert property (@(posedge clock) disable iff (reset)
      nmatch_ff <= MCNT_W'(MAX_MATCHES))
      else $error("match count beyond limit");

   a_walk_push: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WALK && push) |-> pend_valid_ff)
      else $error("result issued without a pending match");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (push && can_push && res.last) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final result");

   a_ins_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("insert did not advance entry count");

endmodule

[rtl/core/hash_join_build_probe.sv]
// ============================================================================
// hash_join_build_probe
// Equi hash join engine: build inserts, probe walks, clear empties the table.
// ============================================================================
// One request is taken at a time. A build does a head lookup, then the entry
// and head write, or issues a full result when the table is full. A probe
// of an empty bucket issues no result; a probe of a chain reads it from the
// head. Probe time is set by the entry memory's single read port, which
// fetches one chain entry per cycle unless a match waits on a full result
// register. Clear takes effect through the per-bucket valid flags; there is
// no clearing pass. Results pass through one output register, so a new
// request may be taken while the last result still waits.
// ============================================================================
module hash_join_build_probe import hjbp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   hjbp_req_if.sink   req,
   hjbp_rsp_if.source rsp
);

   head_port_type     head_port;
   ent_port_type      ent_port;
   logic [EIDX_W-1:0] head_rdata;
   entry_type         ent_rdata;
   logic              can_push;
   logic              push;
   result_type        res;

   // Bucket head memory
   hjbp_ram #(.WIDTH(EIDX_W), .DEPTH(BUCKETS)) u_head_ram (
      .clock (clock),
      .we    (head_port.we),
      .waddr (head_port.waddr),
      .wdata (head_port.wdata),
      .re    (head_port.re),
      .raddr (head_port.raddr),
      .rdata (head_rdata)
   );

   // Entry memory: key, kind, row handle and chain link
   hjbp_ram #(.WIDTH($bits(entry_type)), .DEPTH(ENTRIES)) u_ent_ram (
      .clock (clock),
      .we    (ent_port.we),
      .waddr (ent_port.waddr),
      .wdata (ent_port.wdata),
      .re    (ent_port.re),
      .raddr (ent_port.raddr),
      .rdata (ent_rdata)
   );

   hjbp_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .head_rdata (head_rdata),
      .ent_rdata  (ent_rdata),
      .head_port  (head_port),
      .ent_port   (ent_port),
      .can_push   (can_push),
      .push       (push),
      .res        (res)
   );

   hjbp_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .res      (res),
      .can_push (can_push),
      .rsp      (rsp)
   );

endmodule
